// ----- hdl/lpws_pkg.sv -----
// ----------------------------------------------------------------------------
// lpws_pkg: shared types and constants of the LED pulse width serializer
// Field widths, register indexes, the configuration bundle, the queue entry
// and the tick clamp function.
// ----------------------------------------------------------------------------
package lpws_pkg;

    // Field widths
    localparam int COLOUR_W   = 16;
    localparam int TICK_W     = 16;
    localparam int BRIGHT_W   = 8;
    localparam int PROD_W     = COLOUR_W + BRIGHT_W;
    localparam int WORD_BITS  = 16;
    localparam int IDX_W      = $clog2(WORD_BITS);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_GAP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT    = 3'd5;

    // Reset values of the registers
    localparam logic [TICK_W-1:0]   RST_ONE_HIGH  = 16'd24;
    localparam logic [TICK_W-1:0]   RST_ONE_LOW   = 16'd20;
    localparam logic [TICK_W-1:0]   RST_ZERO_HIGH = 16'd11;
    localparam logic [TICK_W-1:0]   RST_ZERO_LOW  = 16'd28;
    localparam logic [TICK_W-1:0]   RST_LATCH_GAP = 16'd28000;
    localparam logic [BRIGHT_W-1:0] RST_BRIGHT    = 8'd255;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [TICK_W-1:0]   one_high;
        logic [TICK_W-1:0]   one_low;
        logic [TICK_W-1:0]   zero_high;
        logic [TICK_W-1:0]   zero_low;
        logic [TICK_W-1:0]   latch_gap;
        logic [BRIGHT_W-1:0] brightness;
    } lpws_cfg_t;

    typedef struct packed {
        logic                 eof;
        logic [WORD_BITS-1:0] word;
    } lpws_entry_t;

    // A zero tick count is used as one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] t);
        at_least_one = (t == '0) ? TICK_W'(1) : t;
    endfunction

endpackage

// ----- hdl/lpws_front.sv -----
// ----------------------------------------------------------------------------
// lpws_front: input stage
// Accepts colour words, applies the brightness scale and registers the
// result for the queue.
// ----------------------------------------------------------------------------
module lpws_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lpws_pkg::COLOUR_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic [lpws_pkg::BRIGHT_W-1:0] brightness,
    input  logic                          q_ready,
    output logic                          q_push,
    output lpws_pkg::lpws_entry_t         q_entry
);

    logic                          valid_reg;
    lpws_pkg::lpws_entry_t         entry_reg;
    logic [lpws_pkg::PROD_W-1:0]   prod;
    logic [lpws_pkg::COLOUR_W-1:0] scaled;

    // Brightness scale, zero means pass through
    assign prod   = lpws_pkg::PROD_W'(s_tdata) * lpws_pkg::PROD_W'(brightness);
    assign scaled = (brightness == '0) ? s_tdata
                                       : prod[lpws_pkg::PROD_W-1:lpws_pkg::BRIGHT_W];

    assign s_tready = !valid_reg || q_ready;
    assign q_push   = valid_reg;
    assign q_entry  = entry_reg;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            entry_reg.word <= scaled[lpws_pkg::WORD_BITS-1:0];
            entry_reg.eof  <= s_tlast;
        end
    end

endmodule

// ----- hdl/lpws_queue.sv -----
// ----------------------------------------------------------------------------
// lpws_queue: short word queue
// Holds scaled words between the front and the serializer.
// ----------------------------------------------------------------------------
module lpws_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  in_ready,
    input  lpws_pkg::lpws_entry_t push_entry,
    output logic                  out_valid,
    input  logic                  pop,
    output lpws_pkg::lpws_entry_t pop_entry
);

    lpws_pkg::lpws_entry_t             entries_reg [lpws_pkg::QUEUE_DEPTH];
    logic [lpws_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [lpws_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [lpws_pkg::QCNT_W-1:0]       count_reg;
    logic [lpws_pkg::QCNT_W-1:0]       count_next;
    logic                              do_push;
    logic                              do_pop;

    assign in_ready  = (count_reg != lpws_pkg::QCNT_W'(lpws_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;
    assign pop_entry = entries_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hdl/lpws_back.sv -----
// ----------------------------------------------------------------------------
// lpws_back: segment serializer
// Walks the word MSB first, one line segment per cycle unless the output
// stalls, into an output register; appends the latch gap at a frame's end.
// ----------------------------------------------------------------------------
module lpws_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lpws_pkg::lpws_cfg_t         cfg,
    input  logic                        q_valid,
    input  lpws_pkg::lpws_entry_t       q_entry,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lpws_pkg::TICK_W-1:0] m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    logic                           busy_reg;
    logic                           busy_next;
    logic [1:0]                     phase_reg;
    logic [1:0]                     phase_next;
    logic [lpws_pkg::IDX_W-1:0]     idx_reg;
    logic [lpws_pkg::IDX_W-1:0]     idx_next;
    logic [lpws_pkg::WORD_BITS-1:0] word_reg;
    logic                           eof_reg;
    logic                           out_valid_reg;
    logic [lpws_pkg::TICK_W-1:0]    out_ticks_reg;
    logic                           out_level_reg;
    logic                           out_last_reg;

    logic                           adv;
    logic                           load;
    logic                           cur_bit;
    logic                           seg_level;
    logic [lpws_pkg::TICK_W-1:0]    seg_ticks;
    logic                           seg_last;
    logic                           seg_done;

    assign adv     = busy_reg && (!out_valid_reg || m_tready);
    assign cur_bit = word_reg[idx_reg];

    // Segment decode
    always_comb
    begin
        seg_level  = 1'b0;
        seg_ticks  = lpws_pkg::at_least_one(cfg.latch_gap);
        seg_last   = 1'b0;
        seg_done   = 1'b0;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        unique case (phase_reg)
            PH_HIGH:
            begin
                seg_level  = 1'b1;
                seg_ticks  = lpws_pkg::at_least_one(cur_bit ? cfg.one_high : cfg.zero_high);
                phase_next = PH_LOW;
            end
            PH_LOW:
            begin
                seg_ticks = lpws_pkg::at_least_one(cur_bit ? cfg.one_low : cfg.zero_low);
                if (idx_reg == '0)
                begin
                    if (eof_reg)
                    begin
                        phase_next = PH_GAP;
                    end
                    else
                    begin
                        seg_last = 1'b1;
                        seg_done = 1'b1;
                    end
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    phase_next = PH_HIGH;
                end
            end
            PH_GAP:
            begin
                seg_last = 1'b1;
                seg_done = 1'b1;
            end
            default:
            begin
                seg_last = 1'b1;
                seg_done = 1'b1;
            end
        endcase
    end

    // Next word from the queue once the current one is finished
    assign load  = q_valid && (!busy_reg || (adv && seg_done));
    assign q_pop = load;

    always_comb
    begin
        busy_next = busy_reg;
        if (load)
        begin
            busy_next = 1'b1;
        end
        else if (adv && seg_done)
        begin
            busy_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_HIGH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (load)
            begin
                phase_reg <= PH_HIGH;
            end
            else if (adv)
            begin
                phase_reg <= phase_next;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Word, bit index and output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= q_entry.word;
            eof_reg  <= q_entry.eof;
            idx_reg  <= lpws_pkg::IDX_W'(lpws_pkg::WORD_BITS - 1);
        end
        else if (adv)
        begin
            idx_reg <= idx_next;
        end
        if (adv)
        begin
            out_ticks_reg <= seg_ticks;
            out_level_reg <= seg_level;
            out_last_reg  <= seg_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_ticks_reg;
    assign m_tuser  = out_level_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hdl/led_pulse_width_serializer_unit.sv -----
// ----------------------------------------------------------------------------
// led_pulse_width_serializer_unit: one-wire LED pulse segment encoder
// Turns 16-bit colour words into high/low line segments with tick counts.
// ----------------------------------------------------------------------------
// Each accepted colour word is scaled by brightness/256 (brightness 0 leaves
// it as is) and sent MSB first: every bit becomes a high segment and a low
// segment, and a word marked with tlast adds a low latch gap segment. The
// serializer issues one segment per cycle from its output register unless
// the output stalls; a word gives 32 segments, or 33 when it ends a frame.
// The first segment of a word passes the input stage register, the queue
// write, the serializer load and the output register. A two-entry queue sits
// between the input stage and the serializer, so new words are taken while
// segments are still going out. Timing registers written as zero act as one
// tick. Register writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module led_pulse_width_serializer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] colour_word
    input  logic                            s_tlast,   // end_of_frame
    // Output segments
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [15:0] segment_ticks
    output logic                            m_tuser,   // [0] line_level
    output logic                            m_tlast,   // last_segment
    // Register writes
    input  logic                            cfg_we,
    input  logic [lpws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpws_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    lpws_pkg::lpws_cfg_t   cfg_reg;
    logic                  q_ready;
    logic                  q_push;
    lpws_pkg::lpws_entry_t q_in;
    logic                  q_valid;
    logic                  q_pop;
    lpws_pkg::lpws_entry_t q_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_high   <= lpws_pkg::RST_ONE_HIGH;
            cfg_reg.one_low    <= lpws_pkg::RST_ONE_LOW;
            cfg_reg.zero_high  <= lpws_pkg::RST_ZERO_HIGH;
            cfg_reg.zero_low   <= lpws_pkg::RST_ZERO_LOW;
            cfg_reg.latch_gap  <= lpws_pkg::RST_LATCH_GAP;
            cfg_reg.brightness <= lpws_pkg::RST_BRIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpws_pkg::REG_ONE_HIGH:  cfg_reg.one_high   <= cfg_wdata;
                lpws_pkg::REG_ONE_LOW:   cfg_reg.one_low    <= cfg_wdata;
                lpws_pkg::REG_ZERO_HIGH: cfg_reg.zero_high  <= cfg_wdata;
                lpws_pkg::REG_ZERO_LOW:  cfg_reg.zero_low   <= cfg_wdata;
                lpws_pkg::REG_LATCH_GAP: cfg_reg.latch_gap  <= cfg_wdata;
                lpws_pkg::REG_BRIGHT:
                    cfg_reg.brightness <= cfg_wdata[lpws_pkg::BRIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    lpws_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .brightness (cfg_reg.brightness),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    lpws_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .in_ready   (q_ready),
        .push_entry (q_in),
        .out_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_out)
    );

    lpws_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_entry  (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/lpws_checker.sv -----
// ----------------------------------------------------------------------------
// lpws_checker: port level checks of the serializer
// Watches the segment stream on the top level ports.
// ----------------------------------------------------------------------------
module lpws_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled segment stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("segment dropped while stalled");

    // Every segment lasts at least one tick
    a_ticks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata != 16'd0))
        else $error("zero tick segment");

    // A high segment never closes a word
    a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("high segment marked last");

    // The low half of a bit follows its high half at once
    a_low_follows_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser |=> m_tvalid && !m_tuser)
        else $error("low segment missing after high segment");

endmodule

bind led_pulse_width_serializer_unit lpws_checker u_lpws_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/lpws_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpws_scoreboard: segment scoreboard for the LED pulse width serializer
// Watches the word, segment and register-write channels. It keeps its own
// copy of the timing registers and turns every accepted word into the
// expected run of line segments, then compares each accepted segment field
// by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module lpws_scoreboard
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Word channel
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] colour_word
    input  logic                            s_tlast,   // end_of_frame
    // Segment channel
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [15:0]                     m_tdata,   // [15:0] segment_ticks
    input  logic                            m_tuser,   // [0] line_level
    input  logic                            m_tlast,   // last_segment
    // Register writes
    input  logic                            cfg_we,
    input  logic [lpws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpws_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Status for the test top
    output int                              fail_count,
    output int                              pending,
    output int                              words_seen,
    output int                              frames_seen,
    output int                              segments_seen
);
    import lpws_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic              level;
        logic [TICK_W-1:0] ticks;
        logic              last;
    } segment_t;

    segment_t  expected_segments[$];
    lpws_cfg_t timing;
    int        fails;
    int        reports;
    int        n_words;
    int        n_frames;
    int        n_segments;

    // Shortest segment is one tick
    function automatic logic [TICK_W-1:0] floor_one_tick(input logic [TICK_W-1:0] t);
        return t | {{(TICK_W-1){1'b0}}, (t == '0)};
    endfunction

    // Expand one colour word into its high/low segments (plus latch gap)
    function automatic void queue_pulse_train(input logic [COLOUR_W-1:0] colour,
                                              input logic eof);
        logic [PROD_W-1:0]    product;
        logic [COLOUR_W-1:0]  scaled;
        logic [WORD_BITS-1:0] bits;
        logic [TICK_W-1:0]    hi_ticks;
        logic [TICK_W-1:0]    lo_ticks;
        segment_t             seg;
        product = colour * timing.brightness;
        scaled  = (timing.brightness != '0) ? product[PROD_W-1:BRIGHT_W] : colour;
        bits    = scaled[WORD_BITS-1:0];
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            hi_ticks = bits[i] ? timing.one_high : timing.zero_high;
            lo_ticks = bits[i] ? timing.one_low  : timing.zero_low;
            seg = '{level: 1'b1, ticks: floor_one_tick(hi_ticks), last: 1'b0};
            expected_segments.push_back(seg);
            seg = '{level: 1'b0, ticks: floor_one_tick(lo_ticks), last: (i == 0) && !eof};
            expected_segments.push_back(seg);
        end
        if (eof)
        begin
            seg = '{level: 1'b0, ticks: floor_one_tick(timing.latch_gap), last: 1'b1};
            expected_segments.push_back(seg);
        end
    endfunction

    function automatic void flag_failure(input string msg);
        fails++;
        if (reports < MAX_REPORTS)
        begin
            reports++;
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        segment_t want;
        if (!rst_n)
        begin
            expected_segments.delete();
            timing = '{one_high: RST_ONE_HIGH, one_low: RST_ONE_LOW,
                       zero_high: RST_ZERO_HIGH, zero_low: RST_ZERO_LOW,
                       latch_gap: RST_LATCH_GAP, brightness: RST_BRIGHT};
            fails      = 0;
            reports    = 0;
            n_words    = 0;
            n_frames   = 0;
            n_segments = 0;
        end
        else
        begin
            // Register mirror; spare indexes change nothing
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ONE_HIGH:  timing.one_high   = cfg_wdata[TICK_W-1:0];
                    REG_ONE_LOW:   timing.one_low    = cfg_wdata[TICK_W-1:0];
                    REG_ZERO_HIGH: timing.zero_high  = cfg_wdata[TICK_W-1:0];
                    REG_ZERO_LOW:  timing.zero_low   = cfg_wdata[TICK_W-1:0];
                    REG_LATCH_GAP: timing.latch_gap  = cfg_wdata[TICK_W-1:0];
                    REG_BRIGHT:    timing.brightness = cfg_wdata[BRIGHT_W-1:0];
                    default: ;
                endcase
            end

            // Segment compare against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                n_segments++;
                if (expected_segments.size() == 0)
                    flag_failure($sformatf("unexpected segment: level %0b ticks %0d last %0b",
                                           m_tuser, m_tdata, m_tlast));
                else
                begin
                    want = expected_segments.pop_front();
                    if (want.level !== m_tuser || want.ticks !== m_tdata ||
                        want.last !== m_tlast)
                        flag_failure($sformatf({"segment %0d: expected level %0b ticks %0d ",
                                                "last %0b, got level %0b ticks %0d last %0b"},
                                               n_segments, want.level, want.ticks, want.last,
                                               m_tuser, m_tdata, m_tlast));
                end
            end

            // New word request
            if (s_tvalid && s_tready)
            begin
                n_words++;
                if (s_tlast)
                    n_frames++;
                queue_pulse_train(s_tdata, s_tlast);
            end
        end
        fail_count    <= fails;
        pending       <= expected_segments.size();
        words_seen    <= n_words;
        frames_seen   <= n_frames;
        segments_seen <= n_segments;
    end

endmodule

// ----- tb/led_pulse_width_serializer_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pulse_width_serializer_unit_test: stimulus top for the serializer
// Drives colour words and register settings, throttles the segment side,
// and reports the scoreboard's verdict. Directed words cover the extreme
// words, zero tick registers, masked brightness and spare register indexes;
// random frames follow under several timing settings, with one long output
// hold-off and one full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module led_pulse_width_serializer_unit_test;
    import lpws_pkg::*;

    localparam int IDLE_PCT    = 21;
    localparam int HOLD_CYCLES = 500;
    localparam int STALL_LIMIT = 4000;

    // Indexes outside the register map, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;  // [15:0] colour_word
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;         // [15:0] segment_ticks
    logic                  m_tuser;         // [0] line_level
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int words_seen;
    int frames_seen;
    int segments_seen;

    bit tx_idle_on   = 1'b1;
    bit rx_calm      = 1'b0;
    bit hold_request = 1'b0;
    int settings_used = 0;
    int stall_cycles  = 0;

    led_pulse_width_serializer_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lpws_scoreboard scoreboard
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_seen    (words_seen),
        .frames_seen   (frames_seen),
        .segments_seen (segments_seen)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Segment side: random back-pressure, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else
                m_tready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles with no request on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: %0d cycles without a request", stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // One word request, with random gaps ahead of it
    task automatic send_word(input logic [15:0] colour, input logic eof);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= colour;
        s_tlast  <= eof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every expected segment is out
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] one_hi, input logic [15:0] one_lo,
                                  input logic [15:0] zero_hi, input logic [15:0] zero_lo,
                                  input logic [15:0] gap, input logic [15:0] bright);
        write_reg(REG_ONE_HIGH, one_hi);
        write_reg(REG_ONE_LOW, one_lo);
        write_reg(REG_ZERO_HIGH, zero_hi);
        write_reg(REG_ZERO_LOW, zero_lo);
        write_reg(REG_LATCH_GAP, gap);
        write_reg(REG_BRIGHT, bright);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_ticks();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'd0;
        else if (r == 1)
            return 16'hFFFF;
        else if (r < 5)
            return 16'($urandom_range(64, 1));
        else
            return 16'($urandom_range(65535));
    endfunction

    // Upper byte is noise; only the low byte counts
    function automatic logic [15:0] pick_bright();
        int r;
        logic [7:0] b;
        r = $urandom_range(5);
        b = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(255));
        return {8'($urandom_range(255)), b};
    endfunction

    task automatic random_settings();
        apply_settings(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
                       pick_ticks(), pick_bright());
    endtask

    // Mostly whole frames; now and then a frame with random end marks
    task automatic run_frames(input int n_words);
        int         sent;
        int         frame_len;
        bit         broken;
        logic [15:0] colour;
        logic       eof;
        sent = 0;
        while (sent < n_words)
        begin
            frame_len = $urandom_range(6, 1);
            broken    = ($urandom_range(7) == 0);
            for (int j = 0; j < frame_len; j++)
            begin
                case ($urandom_range(9))
                    0:       colour = 16'h0000;
                    1:       colour = 16'hFFFF;
                    default: colour = 16'($urandom_range(65535));
                endcase
                eof = broken ? 1'($urandom_range(1)) : (j == frame_len - 1);
                send_word(colour, eof);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, extreme and alternating words
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h8000, 1'b1);
        send_word(16'h0001, 1'b0);
        send_word(16'h5555, 1'b1);
        send_word(16'hAAAA, 1'b1);
        drain_pipe();

        // Zero tick registers, brightness masked down to zero (no scaling)
        apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFF00);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'h8001, 1'b1);
        send_word(16'h1234, 1'b0);
        send_word(16'hFEDC, 1'b1);
        drain_pipe();

        // Smallest brightness, longest latch gap
        apply_settings(16'd1, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'h0001);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0100, 1'b0);
        send_word(16'h8000, 1'b1);
        drain_pipe();

        // Writes to unmapped indexes must leave the registers alone
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        apply_settings(16'd3, 16'hFFFF, 16'd7, 16'd1, 16'd100, 16'h0080);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        write_reg(REG_SPARE_LO, 16'h0000);
        cfg_we <= 1'b0;
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0001, 1'b1);
        send_word(16'hC3A5, 1'b1);
        send_word(16'h7FFF, 1'b0);
        drain_pipe();

        // Random frames, random settings, both sides idling
        random_settings();
        run_frames(60);
        drain_pipe();

        // No idling on either side
        random_settings();
        tx_idle_on = 1'b0;
        rx_calm    = 1'b1;
        run_frames(60);
        drain_pipe();
        tx_idle_on = 1'b1;
        rx_calm    = 1'b0;

        // Long output hold-off fills the block; then a full drain mid-phase
        random_settings();
        hold_request = 1'b1;
        run_frames(30);
        drain_pipe();
        run_frames(30);
        drain_pipe();

        // All timing at maximum, full brightness
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
        run_frames(60);
        drain_pipe();

        // All timing at zero, no scaling
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
        run_frames(60);
        drain_pipe();

        // Let any stray segment show up
        repeat (10) @(posedge clk);

        $display("Covered %0d colour words in %0d frames, %0d segments checked,",
                 words_seen, frames_seen, segments_seen);
        $display("under %0d register settings incl. zero and full-scale timing",
                 settings_used);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
